@@ sv/resource_toc_decoder_and_lookup_macros.svh @@
// Assertion helper macros shared by the checker.
`ifndef RESOURCE_TOC_DECODER_AND_LOOKUP_MACROS_SVH
`define RESOURCE_TOC_DECODER_AND_LOOKUP_MACROS_SVH
`define RTD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ sv/rtd_pkg.sv @@
//------------------------------------------------------------------------------
// rtd_pkg
// Types and constants of the resource table-of-contents decoder.
//------------------------------------------------------------------------------
`default_nettype none
package rtd_pkg;
    localparam logic [1:0] CMD_TOC    = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] KIND_STORED = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_FINISH = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TRUNCATED = 3'd1;
    localparam logic [2:0] ERR_HEAP      = 3'd2;
    localparam logic [2:0] ERR_ID_RANGE  = 3'd3;
    localparam logic [2:0] ERR_ORDER     = 3'd4;
    localparam logic [2:0] ERR_RESERVED  = 3'd5;
    localparam logic [2:0] ERR_FULL      = 3'd6;

    localparam logic [1:0] PEND_NONE   = 2'd0;
    localparam logic [1:0] PEND_MEDIUM = 2'd1;
    localparam logic [1:0] PEND_LARGE  = 2'd2;
    localparam logic [1:0] PEND_QUAL   = 2'd3;

    localparam logic [29:0] MEDIUM_BIAS = 30'd128;
    localparam logic [29:0] LARGE_BIAS  = 30'd2097279;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  toc_byte;
        logic        toc_last;
        logic [5:0]  query_type;
        logic [9:0]  query_qual;
        logic [15:0] query_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic        found;
        logic [5:0]  res_type;
        logic [9:0]  res_qual;
        logic [15:0] res_id;
        logic [30:0] heap_offset;
        logic [29:0] res_length;
        logic [2:0]  error_code;
    } t_out_item;
endpackage
`default_nettype wire

@@ sv/rtd_stream_if.sv @@
//------------------------------------------------------------------------------
// rtd_stream_if
// Valid/ready channel carrying one item of a given payload type.
//------------------------------------------------------------------------------
`default_nettype none
interface rtd_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/resource_toc_decoder_and_lookup.sv @@
// Timing: a TOC byte is decoded in the cycle after acceptance and its result
// item is valid from the next edge. Each binary-search probe of a lookup reads
// the key memory at the midpoint in S_PROBE and then compares in S_CMP.
// Flow: one item at a time, since a waiting result holds off the input.
// Reset clears all decode state and the heap length.
//------------------------------------------------------------------------------
// resource_toc_decoder_and_lookup
// Decodes table-of-contents bytes into a sorted resource table in memory and
// answers lookups by binary search.
//------------------------------------------------------------------------------
`default_nettype none
module resource_toc_decoder_and_lookup
    import rtd_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [30:0] i_cfg_data,
    rtd_stream_if.sink   in_if,
    rtd_stream_if.source out_if
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_TOC   = 5'b00010,
        S_PROBE = 5'b00100,
        S_CMP   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    logic [31:0] key_mem [TABLE_DEPTH];
    logic [60:0] loc_mem [TABLE_DEPTH];
    logic [31:0] r_key_rd;
    logic [60:0] r_loc_rd;
    logic        mem_we;
    logic [AW-1:0] mem_wa, rd_addr;
    logic [31:0] mem_wkey;
    logic [60:0] mem_wloc;

    t_state      r_state, n_state;
    t_in_item    r_item;
    t_out_item   r_out, n_out;
    logic [30:0] r_heap_length;
    logic [6:0]  r_type, n_type;
    logic [10:0] r_qual, n_qual;
    logic [16:0] r_id, n_id;
    logic [30:0] r_heap_pos, n_heap_pos;
    logic [1:0]  r_pcode, n_pcode;
    logic [1:0]  r_pbytes, n_pbytes;
    logic [28:0] r_pval, n_pval;
    logic [CW-1:0] r_count, n_count;
    logic        r_err, n_err;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [CW-1:0] mid;

    assign mid = CW'((r_lo + r_hi) >> 1);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            key_mem[mem_wa] <= mem_wkey;
            loc_mem[mem_wa] <= mem_wloc;
        end
        r_key_rd <= key_mem[rd_addr];
        r_loc_rd <= loc_mem[rd_addr];
    end

    always_comb begin
        rd_addr = (r_count == '0) ? '0 : AW'(r_count - 1'b1);
        if (r_state == S_PROBE) begin
            rd_addr = mid[AW-1:0];
        end
    end

    assign in_if.ready = (r_state == S_IDLE);
    assign out_if.valid = (r_state == S_OUT);
    assign out_if.data = r_out;

    logic [7:0]  b;
    logic [31:0] qkey;
    always_comb begin
        logic        have_len, stored, fail;
        logic [2:0]  ecode;
        logic [29:0] len;
        logic [28:0] pv;
        logic [31:0] key;
        logic [31:0] hsum;
        logic [17:0] ts;
        n_state = r_state;
        n_out = r_out;
        n_type = r_type; n_qual = r_qual; n_id = r_id; n_heap_pos = r_heap_pos;
        n_pcode = r_pcode; n_pbytes = r_pbytes; n_pval = r_pval;
        n_count = r_count; n_err = r_err; n_lo = r_lo; n_hi = r_hi;
        mem_we = 1'b0; mem_wa = r_count[AW-1:0];
        mem_wkey = '0; mem_wloc = '0;
        b = r_item.toc_byte;
        qkey = {r_item.query_type, r_item.query_qual, r_item.query_id};
        have_len = 1'b0; stored = 1'b0; fail = 1'b0; ecode = ERR_NONE;
        len = '0; pv = '0; key = '0; hsum = '0; ts = '0;
        case (r_state)
            S_IDLE: begin
                if (in_if.valid) begin
                    case (in_if.data.command)
                        CMD_TOC: if (!r_err) n_state = S_TOC;
                        CMD_LOOKUP: begin
                            n_lo = '0;
                            n_hi = (r_count > DEPTH_C) ? DEPTH_C : r_count;
                            n_state = S_PROBE;
                        end
                        CMD_CLEAR: begin
                            n_type = 7'd1; n_qual = '0; n_id = 17'd1; n_heap_pos = '0;
                            n_pcode = PEND_NONE; n_pbytes = '0; n_pval = '0;
                            n_count = '0; n_err = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_TOC: begin
                n_out = '0;
                if (r_pcode == PEND_NONE) begin
                    if (!b[7]) begin
                        len = {22'd0, b}; have_len = 1'b1;
                    end else begin
                        case (b[7:5])
                            3'b100: begin
                                n_pcode = PEND_MEDIUM; n_pbytes = 2'd2; n_pval = {24'd0, b[4:0]};
                            end
                            3'b101: begin
                                n_pcode = PEND_LARGE; n_pbytes = 2'd3; n_pval = {24'd0, b[4:0]};
                            end
                            3'b110: begin
                                if (b[4]) begin
                                    ts = {1'b0, r_id} + {14'd0, b[3:0]} + 18'd1;
                                    n_id = (ts > 18'd65536) ? 17'd65536 : ts[16:0];
                                end else if (b[4:2] != 3'd0) begin
                                    fail = 1'b1; ecode = ERR_RESERVED;
                                end else begin
                                    n_pcode = PEND_QUAL; n_pbytes = 2'd1;
                                    n_pval = {27'd0, b[1:0]};
                                end
                            end
                            default: begin
                                ts = {11'd0, r_type} + {13'd0, b[4:0]} + 18'd1;
                                n_type = (ts > 18'd64) ? 7'd64 : ts[6:0];
                                n_qual = '0; n_id = 17'd1;
                            end
                        endcase
                    end
                end else begin
                    pv = {r_pval[20:0], b};
                    n_pval = pv;
                    n_pbytes = r_pbytes - 2'd1;
                    if (r_pbytes == 2'd1) begin
                        case (r_pcode)
                            PEND_MEDIUM: begin
                                len = {1'b0, pv} + MEDIUM_BIAS; have_len = 1'b1;
                            end
                            PEND_LARGE: begin
                                len = {1'b0, pv} + LARGE_BIAS; have_len = 1'b1;
                            end
                            default: begin
                                ts = {7'd0, r_qual} + {7'd0, pv[10:0]} + 18'd1;
                                n_qual = (ts > 18'd1024) ? 11'd1024 : ts[10:0];
                                n_id = 17'd1;
                            end
                        endcase
                        n_pcode = PEND_NONE; n_pval = '0;
                    end
                end
                if (have_len) begin
                    hsum = {1'b0, r_heap_pos} + {2'd0, len};
                    key = {r_type[5:0], r_qual[9:0], r_id[15:0]};
                    if (hsum > {1'b0, r_heap_length}) begin
                        fail = 1'b1; ecode = ERR_HEAP;
                    end else if (len != '0) begin
                        if (r_type == 7'd0 || r_type[6] || r_qual[10] || r_id[16]) begin
                            fail = 1'b1; ecode = ERR_ID_RANGE;
                        end else if (r_count != '0 && key <= r_key_rd) begin
                            fail = 1'b1; ecode = ERR_ORDER;
                        end else if (r_count >= DEPTH_C) begin
                            fail = 1'b1; ecode = ERR_FULL;
                        end else begin
                            mem_we = 1'b1; mem_wkey = key;
                            mem_wloc = {r_heap_pos, len};
                            n_count = r_count + 1'b1;
                            stored = 1'b1;
                            n_out.result_kind = KIND_STORED;
                            n_out.res_type = r_type[5:0]; n_out.res_qual = r_qual[9:0];
                            n_out.res_id = r_id[15:0]; n_out.heap_offset = r_heap_pos;
                            n_out.res_length = len;
                        end
                    end
                    if (!fail) begin
                        n_heap_pos = hsum[30:0];
                        n_id = r_id[16] ? r_id : r_id + 17'd1;
                    end
                end
                if (!fail && r_item.toc_last && n_pcode != PEND_NONE) begin
                    fail = 1'b1; ecode = ERR_TRUNCATED;
                end
                if (fail) begin
                    mem_we = 1'b0;
                    n_out = '0; n_out.result_kind = KIND_ERROR; n_out.error_code = ecode;
                    n_count = '0; n_err = 1'b1; n_state = S_OUT;
                end else if (r_item.toc_last) begin
                    n_out.result_kind = KIND_FINISH; n_state = S_OUT;
                end else begin
                    n_state = stored ? S_OUT : S_IDLE;
                end
            end
            S_PROBE: begin
                n_out = '0; n_out.result_kind = KIND_LOOKUP;
                n_out.res_type = r_item.query_type; n_out.res_qual = r_item.query_qual;
                n_out.res_id = r_item.query_id;
                if (r_item.query_type == '0 || r_item.query_id == '0 || r_lo >= r_hi) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (qkey < r_key_rd) begin
                    n_hi = mid; n_state = S_PROBE;
                end else if (qkey > r_key_rd) begin
                    n_lo = mid + 1'b1; n_state = S_PROBE;
                end else begin
                    n_out.found = 1'b1;
                    n_out.heap_offset = r_loc_rd[60:30];
                    n_out.res_length = r_loc_rd[29:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: if (out_if.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_heap_length <= '0;
            r_type <= 7'd1; r_qual <= '0; r_id <= 17'd1; r_heap_pos <= '0;
            r_pcode <= PEND_NONE; r_pbytes <= '0; r_pval <= '0;
            r_count <= '0; r_err <= 1'b0; r_lo <= '0; r_hi <= '0;
        end else begin
            if (i_cfg_we) r_heap_length <= i_cfg_data;
            r_state <= n_state;
            r_type <= n_type; r_qual <= n_qual; r_id <= n_id; r_heap_pos <= n_heap_pos;
            r_pcode <= n_pcode; r_pbytes <= n_pbytes; r_pval <= n_pval;
            r_count <= n_count; r_err <= n_err; r_lo <= n_lo; r_hi <= n_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_if.valid && in_if.ready) r_item <= in_if.data;
    end
endmodule
`default_nettype wire

@@ sv/rtd_checker.sv @@
//------------------------------------------------------------------------------
// rtd_checker
// Port-level checks of the resource table-of-contents decoder.
//------------------------------------------------------------------------------
`default_nettype none
`include "resource_toc_decoder_and_lookup_macros.svh"
module rtd_checker
    import rtd_pkg::*;
(
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            in_ready,
    input wire            out_valid,
    input wire            out_ready,
    input wire t_out_item out_data
);
    wire stall;
    wire non_error;
    wire err_ok;
    wire found_c;
    wire found_ok;

    assign stall     = out_valid && !out_ready;
    assign non_error = out_valid && out_data.result_kind != KIND_ERROR;
    assign err_ok    = out_data.error_code == ERR_NONE;
    assign found_c   = out_valid && out_data.found;
    assign found_ok  = out_data.result_kind == KIND_LOOKUP && out_data.res_length != '0;

    `RTD_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, out_valid, !in_ready, "ready with result")
    `RTD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, stall, out_valid && $stable(out_data), "result lost")
    `RTD_ASSERT_IMPL(a_err_code, i_clk, i_rst_n, non_error, err_ok, "stray error code")
    `RTD_ASSERT_IMPL(a_found, i_clk, i_rst_n, found_c, found_ok, "bad found")
endmodule

bind resource_toc_decoder_and_lookup rtd_checker u_rtd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_ready(in_if.ready),
    .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);
`default_nettype wire

@@ verif/testbench.sv @@
//------------------------------------------------------------------------------
// Resource table-of-contents decoder testbench
// Drives TOC bytes, lookups and clear commands through the input channel,
// predicts each result with a behavioral copy of the decoder, and checks every
// result item field by field under random gaps and output stalls.
//------------------------------------------------------------------------------
`default_nettype none
module testbench
    import rtd_pkg::*;
();

    localparam int DEPTH = 1024;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [30:0] HEAP_MAX = 31'h7fffffff;

    class resource_table_model;
        bit [30:0] heap_length;
        bit [6:0]  cur_type;
        bit [10:0] cur_qual;
        bit [16:0] cur_id;
        bit [30:0] heap_pos;
        bit [1:0]  pend_code;
        bit [1:0]  pend_bytes;
        bit [28:0] pend_value;
        bit [10:0] count;
        bit        err_flag;
        bit [31:0] keys [DEPTH];
        bit [30:0] offs [DEPTH];
        bit [29:0] lens [DEPTH];
        t_out_item awaited [$];
        int errors;
        int n_stored, n_lookup, n_found, n_error, n_finish;

        function void clear_decode();
            cur_type = 1; cur_qual = 0; cur_id = 1; heap_pos = 0;
            pend_code = PEND_NONE; pend_bytes = 0; pend_value = 0;
            count = 0; err_flag = 0;
        endfunction

        function new();
            heap_length = 0;
            clear_decode();
            errors = 0;
        endfunction

        function int unsigned sat(int unsigned v, int unsigned d, int unsigned lim);
            longint unsigned s;
            s = longint'(v) + d;
            return (s > lim) ? lim : int'(s);
        endfunction

        function bit fail(logic [2:0] code, output t_out_item r);
            r = '0;
            r.result_kind = KIND_ERROR;
            r.error_code = code;
            count = 0;
            err_flag = 1;
            return 1;
        endfunction

        function bit toc_step(bit [7:0] b, bit last, output t_out_item r);
            bit have_len, stored;
            bit [29:0] len;
            bit [31:0] key;
            r = '0;
            have_len = 0; stored = 0; len = 0;
            if (pend_code == PEND_NONE) begin
                if (b < 8'h80) begin
                    len = 30'(b); have_len = 1;
                end else begin
                    case (b & 8'he0)
                        8'h80: begin
                            pend_code = PEND_MEDIUM; pend_bytes = 2; pend_value = 29'(b[4:0]);
                        end
                        8'ha0: begin
                            pend_code = PEND_LARGE; pend_bytes = 3; pend_value = 29'(b[4:0]);
                        end
                        8'hc0: begin
                            if ((b & 8'hf0) == 8'hd0) begin
                                cur_id = 17'(sat(cur_id, b[3:0] + 1, 65536));
                            end else if (b & 8'h1c) begin
                                return fail(ERR_RESERVED, r);
                            end else begin
                                pend_code = PEND_QUAL; pend_bytes = 1; pend_value = 29'(b[1:0]);
                            end
                        end
                        default: begin
                            cur_type = 7'(sat(cur_type, b[4:0] + 1, 64));
                            cur_qual = 0; cur_id = 1;
                        end
                    endcase
                end
            end else begin
                pend_value = {pend_value[20:0], b};
                if (pend_bytes > 0) pend_bytes--;
                if (pend_bytes == 0) begin
                    if (pend_code == PEND_MEDIUM) begin
                        len = pend_value + MEDIUM_BIAS; have_len = 1;
                    end else if (pend_code == PEND_LARGE) begin
                        len = pend_value + LARGE_BIAS; have_len = 1;
                    end else begin
                        cur_qual = 11'(sat(cur_qual, pend_value + 1, 1024));
                        cur_id = 1;
                    end
                    pend_code = PEND_NONE; pend_value = 0;
                end
            end
            if (have_len) begin
                if (longint'(heap_pos) + len > longint'(heap_length))
                    return fail(ERR_HEAP, r);
                if (len != 0) begin
                    if (cur_type < 1 || cur_type > 63 || cur_qual > 1023 || cur_id > 65535)
                        return fail(ERR_ID_RANGE, r);
                    key = {cur_type[5:0], cur_qual[9:0], cur_id[15:0]};
                    if (count > 0 && key <= keys[(count - 1) % DEPTH])
                        return fail(ERR_ORDER, r);
                    if (count >= DEPTH) return fail(ERR_FULL, r);
                    keys[count] = key;
                    offs[count] = heap_pos;
                    lens[count] = len;
                    count++;
                    r.result_kind = KIND_STORED;
                    r.res_type = cur_type[5:0];
                    r.res_qual = cur_qual[9:0];
                    r.res_id = cur_id[15:0];
                    r.heap_offset = heap_pos;
                    r.res_length = len;
                    stored = 1;
                end
                heap_pos += len;
                cur_id = 17'(sat(cur_id, 1, 65536));
            end
            if (last) begin
                if (pend_code != PEND_NONE) return fail(ERR_TRUNCATED, r);
                r.result_kind = KIND_FINISH;
                return 1;
            end
            return stored;
        endfunction

        function void find_key(bit [5:0] t, bit [9:0] q, bit [15:0] id, output t_out_item r);
            int lo, hi, mid;
            bit [31:0] key;
            r = '0;
            r.result_kind = KIND_LOOKUP;
            r.res_type = t; r.res_qual = q; r.res_id = id;
            if (t != 0 && id != 0) begin
                key = {t, q, id};
                lo = 0;
                hi = (count > DEPTH) ? DEPTH : count;
                while (lo < hi) begin
                    mid = (lo + hi) >> 1;
                    if (key < keys[mid]) hi = mid;
                    else if (key > keys[mid]) lo = mid + 1;
                    else begin
                        r.found = 1;
                        r.heap_offset = offs[mid];
                        r.res_length = lens[mid];
                        break;
                    end
                end
            end
        endfunction

        function void note_input(t_in_item it);
            t_out_item r;
            bit has;
            has = 0;
            if (it.command == CMD_TOC) begin
                if (!err_flag) has = toc_step(it.toc_byte, it.toc_last, r);
            end else if (it.command == CMD_LOOKUP) begin
                find_key(it.query_type, it.query_qual, it.query_id, r);
                has = 1;
            end else if (it.command == CMD_CLEAR) begin
                clear_decode();
            end
            if (has) begin
                awaited.push_back(r);
                case (r.result_kind)
                    KIND_STORED: n_stored++;
                    KIND_LOOKUP: begin n_lookup++; if (r.found) n_found++; end
                    KIND_ERROR:  n_error++;
                    default:     n_finish++;
                endcase
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("mismatch: %s", msg);
        endtask

        task cmp(string name, longint unsigned got, longint unsigned want);
            if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check(t_out_item got);
            t_out_item w;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result item %h", got));
                return;
            end
            w = awaited.pop_front();
            cmp("result_kind", got.result_kind, w.result_kind);
            cmp("found", got.found, w.found);
            cmp("res_type", got.res_type, w.res_type);
            cmp("res_qual", got.res_qual, w.res_qual);
            cmp("res_id", got.res_id, w.res_id);
            cmp("heap_offset", got.heap_offset, w.heap_offset);
            cmp("res_length", got.res_length, w.res_length);
            cmp("error_code", got.error_code, w.error_code);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [30:0] i_cfg_data;

    rtd_stream_if #(.T(t_in_item))  in_ch ();
    rtd_stream_if #(.T(t_out_item)) out_ch ();

    resource_toc_decoder_and_lookup #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .in_if      (in_ch.sink),
        .out_if     (out_ch.source)
    );

    resource_table_model table_model;
    int  cycles;
    int  items_sent;
    bit  calm;
    bit  held;
    int  stall_left;

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_data = '0;
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
        cycles = 0;
        calm = 0;
        held = 0;
        stall_left = 0;
        table_model = new();
    end

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: done, errors");
            $finish;
        end
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 0;
            stall_left <= stall_left - 1;
        end else begin
            out_ch.ready <= 1;
            stall_left <= pick_gap();
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) table_model.check(out_ch.data);
    end

    task send_item(t_in_item it);
        int gap;
        in_ch.valid <= 1;
        in_ch.data <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        table_model.note_input(it);
        items_sent++;
        gap = pick_gap();
        held = (gap == 0);
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task drop_valid();
        if (held) begin
            in_ch.valid <= 0;
            held = 0;
        end
    endtask

    function t_in_item rand_item(logic [1:0] cmd);
        t_in_item it;
        it.command = cmd;
        it.toc_byte = 8'($urandom);
        it.toc_last = 1'($urandom);
        it.query_type = 6'($urandom);
        it.query_qual = 10'($urandom);
        it.query_id = 16'($urandom);
        return it;
    endfunction

    task send_toc(bit [7:0] b, bit last);
        t_in_item it;
        it = rand_item(CMD_TOC);
        it.toc_byte = b;
        it.toc_last = last;
        send_item(it);
    endtask

    task send_lookup(bit [5:0] t, bit [9:0] q, bit [15:0] id);
        t_in_item it;
        it = rand_item(CMD_LOOKUP);
        it.query_type = t;
        it.query_qual = q;
        it.query_id = id;
        send_item(it);
    endtask

    task send_clear();
        send_item(rand_item(CMD_CLEAR));
    endtask

    task drain_and_set_heap(bit [30:0] v);
        drop_valid();
        while (table_model.awaited.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        table_model.heap_length = v;
    endtask

    function bit rand_last();
        return $urandom_range(0, 24) == 0;
    endfunction

    task random_burst();
        int r, k;
        bit [31:0] key;
        r = $urandom_range(0, 99);
        if (table_model.err_flag && r < 40) begin
            send_clear();
        end else if (r < 30) begin
            send_toc(($urandom_range(0, 15) == 0) ? 8'h00 : 8'($urandom_range(1, 127)),
                     rand_last());
        end else if (r < 38) begin
            send_toc(8'h80 | 8'($urandom_range(0, 31)), 0);
            send_toc(8'($urandom), 0);
            send_toc(8'($urandom), rand_last());
        end else if (r < 43) begin
            send_toc(8'ha0 | 8'($urandom_range(0, 31)), 0);
            repeat (2) send_toc(8'($urandom), 0);
            send_toc(8'($urandom), rand_last());
        end else if (r < 50) begin
            send_toc(8'hd0 | 8'($urandom_range(0, 15)), rand_last());
        end else if (r < 56) begin
            send_toc(8'hc0 | 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 0), 0);
            send_toc(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)),
                     rand_last());
        end else if (r < 61) begin
            send_toc(8'he0 | 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                              : $urandom_range(0, 1)),
                     rand_last());
        end else if (r < 78) begin
            if (table_model.count > 0 && $urandom_range(0, 2) != 0) begin
                k = $urandom_range(0, table_model.count - 1);
                key = table_model.keys[k];
                if ($urandom_range(0, 4) == 0) key = key + 1;
                send_lookup(key[31:26], key[25:16], key[15:0]);
            end else begin
                send_item(rand_item(CMD_LOOKUP));
            end
        end else if (r < 81) begin
            send_clear();
        end else if (r < 83) begin
            send_item(rand_item(2'd3));
        end else if (r < 87) begin
            send_toc(8'($urandom), rand_last());
        end else if (r < 89) begin
            send_toc(8'h80 | 8'($urandom_range(0, 31)), 0);
            send_toc(8'($urandom), 1);
        end else begin
            send_toc(8'($urandom_range(1, 127)), 0);
        end
    endtask

    bit [30:0] phase_heap [6];

    initial begin
        items_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part: extremes of each code, saturation, errors and lookups.
        drain_and_set_heap(HEAP_MAX);
        send_toc(8'h00, 0);
        send_toc(8'h7f, 0);
        send_toc(8'h80, 0); send_toc(8'h00, 0); send_toc(8'h00, 0);
        send_toc(8'h9f, 0); send_toc(8'hff, 0); send_toc(8'hff, 0);
        send_toc(8'ha0, 0); send_toc(8'h00, 0); send_toc(8'h00, 0); send_toc(8'h00, 0);
        send_toc(8'hdf, 0);
        send_toc(8'h05, 1);
        send_lookup(6'd1, 10'd0, 16'd2);
        send_lookup(6'd0, 10'd0, 16'd2);
        send_lookup(6'd1, 10'd0, 16'd0);
        send_toc(8'hc3, 0); send_toc(8'hff, 0);
        send_toc(8'h01, 0);
        send_toc(8'h01, 0);
        send_clear();
        send_toc(8'hc4, 0);
        send_clear();
        send_toc(8'hff, 0); send_toc(8'hff, 0); send_toc(8'h01, 0);
        send_clear();
        send_toc(8'h80, 1);
        send_item(rand_item(2'd3));
        send_clear();
        drain_and_set_heap(31'd10);
        send_toc(8'h0a, 0);
        send_toc(8'h00, 1);
        send_toc(8'h01, 0);
        send_clear();

        // Fill the whole table, then one more entry overflows it.
        drain_and_set_heap(HEAP_MAX);
        calm = 1;
        repeat (DEPTH + 1) send_toc(8'h01, 0);
        calm = 0;
        send_lookup(6'd1, 10'd0, 16'd500);
        send_clear();

        phase_heap[0] = HEAP_MAX;
        phase_heap[1] = 31'd0;
        phase_heap[2] = 31'd600;
        phase_heap[3] = 31'd3000000;
        phase_heap[4] = 31'($urandom);
        phase_heap[5] = HEAP_MAX;
        items_sent = 0;
        for (int p = 0; p < 6; p++) begin
            drain_and_set_heap(phase_heap[p]);
            calm = (p == 3);
            while (items_sent < (p + 1) * 148) random_burst();
        end
        calm = 0;

        drop_valid();
        while (table_model.awaited.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("covered %0d stores, %0d lookups (%0d hits), %0d errors, %0d finishes",
                 table_model.n_stored, table_model.n_lookup, table_model.n_found,
                 table_model.n_error, table_model.n_finish);
        $display("heap limits from zero to the 31-bit maximum; %0d mismatches",
                 table_model.errors);
        if (table_model.errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+sv
sv/rtd_pkg.sv
sv/rtd_stream_if.sv
sv/resource_toc_decoder_and_lookup.sv
sv/rtd_checker.sv
verif/testbench.sv
